>>> rtl/core/direct_mapped_transposition_table_core_assert.svh
// assertion macros for the transposition table core
// expects signals named clock and reset in the including scope
`ifndef DIRECT_MAPPED_TRANSPOSITION_TABLE_CORE_ASSERT_SVH
`define DIRECT_MAPPED_TRANSPOSITION_TABLE_CORE_ASSERT_SVH

// checked outside reset
`define DMTT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define DMTT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/dmtt_pkg.sv
// shared types and constants for the transposition table core
// no dependencies
`default_nettype none

package dmtt_pkg;

   localparam int OP_W      = 2;
   localparam int KEY_W     = 64;
   localparam int VISITS_W  = 32;
   localparam int EVAL_W    = 48;
   localparam int SLOT_SEL_W = 32;
   localparam int EPOCH_W   = 8;

   typedef enum logic [OP_W-1:0] {
      OP_STORE     = 2'd0,
      OP_PROBE     = 2'd1,
      OP_CLEAR_ONE = 2'd2,
      OP_CLEAR_ALL = 2'd3
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [KEY_W-1:0]     key;
      logic [VISITS_W-1:0]  visits;
      logic [EVAL_W-1:0]    eval_sum;
   } item_type;

   typedef struct packed {
      logic [VISITS_W-1:0]  visits;
      logic [EVAL_W-1:0]    eval_sum;
   } stat_type;

   typedef struct packed {
      logic                 live;
      logic [EPOCH_W-1:0]   epoch;
   } tag_type;

endpackage

`default_nettype wire

>>> rtl/core/dmtt_channels.sv
// request and response channel interfaces for the transposition table core
// depends on dmtt_pkg
`default_nettype none

interface dmtt_req_if import dmtt_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [KEY_W-1:0]    key;
   logic [VISITS_W-1:0] visits;
   logic [EVAL_W-1:0]   eval_sum;

   modport source (output valid, operation, key, visits, eval_sum, input ready);
   modport sink (input valid, operation, key, visits, eval_sum, output ready);
endinterface

interface dmtt_rsp_if import dmtt_pkg::*;;
   logic                valid;
   logic                ready;
   logic                take;
   logic [VISITS_W-1:0] visits_out;
   logic [EVAL_W-1:0]   eval_out;

   modport source (output valid, take, visits_out, eval_out, input ready);
   modport sink (input valid, take, visits_out, eval_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dmtt_slot_index.sv
// three-stage slot index unit: low key bits modulo the table size
// reciprocal multiply, back-multiply, one correcting subtract; depends on dmtt_pkg
`default_nettype none

module dmtt_slot_index import dmtt_pkg::*; #(
   parameter int TABLE_ENTRIES = 4096,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [SLOT_SEL_W-1:0] key_low,
   output logic      [IDX_W-1:0]      slot_idx
);

   localparam int REM_W = IDX_W + 1;
   localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(TABLE_ENTRIES);
   localparam logic [32:0] RECIP = RECIP_WIDE[32:0];
   localparam logic [REM_W-1:0] ENTRIES_R = REM_W'(TABLE_ENTRIES);

   logic [SLOT_SEL_W-1:0] quot_ff, quot_in;
   logic [REM_W-1:0]      xa_ff, xb_ff;
   logic [REM_W-1:0]      back_ff, back_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [64:0]           prod_wide;
   logic [REM_W-1:0]      rem;

   always_comb begin
      prod_wide = 65'(key_low) * 65'(RECIP);
      quot_in   = prod_wide[63:32];
      back_in   = quot_ff[REM_W-1:0] * ENTRIES_R;
      rem       = xb_ff - back_ff;
      if (rem >= ENTRIES_R) begin
         slot_in = IDX_W'(rem - ENTRIES_R);
      end else begin
         slot_in = rem[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
         xa_ff   <= key_low[REM_W-1:0];
         back_ff <= back_in;
         xb_ff   <= xa_ff;
         slot_ff <= slot_in;
      end
   end

   assign slot_idx = slot_ff;

endmodule

`default_nettype wire

>>> rtl/core/direct_mapped_transposition_table_core.sv
// throughput: one transaction per cycle; index, memory and compare stages share one stall
// reset: a clearing pass sweeps the tag memory, no transaction taken
// clear-all bumps an epoch; every 256th clear-all repeats the clearing pass
// depends on dmtt_pkg, dmtt_channels, dmtt_slot_index and the assertion header
`default_nettype none
`include "direct_mapped_transposition_table_core_assert.svh"

module direct_mapped_transposition_table_core import dmtt_pkg::*; #(
   parameter int TABLE_ENTRIES = 4096
) (
   input wire logic    clock,
   input wire logic    reset,
   dmtt_req_if.sink    req_chan,
   dmtt_rsp_if.source  rsp_chan
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam int STAGES = 5;

   // memories
   logic [KEY_W-1:0] key_mem  [TABLE_ENTRIES];
   stat_type         stat_mem [TABLE_ENTRIES];
   tag_type          tag_mem  [TABLE_ENTRIES];

   logic [KEY_W-1:0] key_rd_ff;
   stat_type         stat_rd_ff;
   tag_type          tag_rd_ff;

   // pipeline
   logic [STAGES-1:0] vld_ff, vld_in;
   item_type          pipe_ff [STAGES];
   item_type          pipe_in [STAGES];

   logic               sweep_ff, sweep_in;
   logic [IDX_W-1:0]   sweep_idx_ff, sweep_idx_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                take_ff, take_in;
   logic [VISITS_W-1:0] visits_out_ff, visits_out_in;
   logic [EVAL_W-1:0]   eval_out_ff, eval_out_in;

   logic             adv, en, accept, mem_op;
   logic [IDX_W-1:0] slot_idx;
   item_type         cur, fin;
   logic             live;
   logic [KEY_W-1:0] seen_key;
   logic [VISITS_W-1:0] seen_visits;

   assign adv    = !rsp_valid_ff || rsp_chan.ready;
   assign en     = adv && !sweep_ff;
   assign accept = req_chan.valid && en;
   assign req_chan.ready = en;

   assign cur    = pipe_ff[3];
   assign fin    = pipe_ff[4];
   assign mem_op = vld_ff[3] && en;

   dmtt_slot_index #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_index (
      .clock    (clock),
      .en       (en),
      .key_low  (pipe_ff[0].key[SLOT_SEL_W-1:0]),
      .slot_idx (slot_idx)
   );

   always_comb begin
      pipe_in[0].operation = op_type'(req_chan.operation);
      pipe_in[0].key       = req_chan.key;
      pipe_in[0].visits    = req_chan.visits;
      pipe_in[0].eval_sum  = req_chan.eval_sum;
      for (int i = 1; i < STAGES; i++) begin
         pipe_in[i] = pipe_ff[i-1];
      end
      vld_in = {vld_ff[STAGES-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   // memory access stage
   always_ff @(posedge clock) begin
      if (mem_op && cur.operation == OP_STORE) begin
         key_mem[slot_idx]  <= cur.key;
         stat_mem[slot_idx] <= '{visits: cur.visits, eval_sum: cur.eval_sum};
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         tag_mem[sweep_idx_ff] <= '{live: 1'b0, epoch: '0};
      end else if (mem_op && cur.operation == OP_STORE) begin
         tag_mem[slot_idx] <= '{live: 1'b1, epoch: epoch_ff};
      end else if (mem_op && cur.operation == OP_CLEAR_ONE) begin
         tag_mem[slot_idx] <= '{live: 1'b0, epoch: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_op) begin
         key_rd_ff  <= key_mem[slot_idx];
         stat_rd_ff <= stat_mem[slot_idx];
         tag_rd_ff  <= tag_mem[slot_idx];
      end
   end

   // epoch and clearing pass
   always_comb begin
      sweep_in     = sweep_ff;
      sweep_idx_in = sweep_idx_ff;
      epoch_in     = epoch_ff;
      if (sweep_ff) begin
         sweep_idx_in = sweep_idx_ff + 1'b1;
         if (sweep_idx_ff == LAST_IDX) begin
            sweep_in = 1'b0;
         end
      end else if (mem_op && cur.operation == OP_CLEAR_ALL) begin
         epoch_in = epoch_ff + 1'b1;
         if (&epoch_ff) begin
            sweep_in     = 1'b1;
            sweep_idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_idx_ff <= '0;
         epoch_ff     <= '0;
      end else begin
         sweep_ff     <= sweep_in;
         sweep_idx_ff <= sweep_idx_in;
         epoch_ff     <= epoch_in;
      end
   end

   // compare stage
   always_comb begin
      live        = tag_rd_ff.live && (tag_rd_ff.epoch == epoch_ff);
      seen_key    = live ? key_rd_ff : '0;
      seen_visits = live ? stat_rd_ff.visits : '0;
      take_in     = (fin.operation == OP_PROBE) && (seen_key == fin.key) &&
                    (seen_visits > fin.visits);
      visits_out_in = take_in ? seen_visits : '0;
      eval_out_in   = take_in ? stat_rd_ff.eval_sum : '0;
      rsp_valid_in  = adv ? (vld_ff[4] && !sweep_ff) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         take_ff       <= take_in;
         visits_out_ff <= visits_out_in;
         eval_out_ff   <= eval_out_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.take       = take_ff;
   assign rsp_chan.visits_out = visits_out_ff;
   assign rsp_chan.eval_out   = eval_out_ff;

   `DMTT_ASSERT_ALWAYS(a_reset_sweep, reset |=> sweep_ff && epoch_ff == '0, "no sweep after reset")
   `DMTT_ASSERT(a_wrap_sweep, mem_op && cur.operation == OP_CLEAR_ALL && &epoch_ff |=> sweep_ff && epoch_ff == '0, "epoch wrap without sweep")
   `DMTT_ASSERT(a_take_visits, rsp_valid_ff && take_ff |-> visits_out_ff != '0, "take with zero visits")
   `DMTT_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(vld_ff[4]), "response without transaction")

endmodule

`default_nettype wire

>>> bench/tb.sv
// testbench for direct_mapped_transposition_table_core: directed and random store, probe and
// clear transactions, with replies checked against a scoreboard that mirrors the slot table
// depends on dmtt_pkg, dmtt_channels and the core
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dmtt_pkg::*;

   localparam int TABLE_ENTRIES = 4096;
   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam int CLK_PERIOD = 10;
   localparam int HOT_SLOTS = 32;
   localparam int UPPER_KEYS = 4;
   localparam int CHURN_CLEARS = 270;
   localparam int TAIL_ITEMS = 600;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                take;
      logic [VISITS_W-1:0] visits;
      logic [EVAL_W-1:0]   eval_sum;
   } reply_type;

   class transposition_scoreboard;
      logic [KEY_W-1:0]    keys [TABLE_ENTRIES];
      logic [VISITS_W-1:0] counts [TABLE_ENTRIES];
      logic [EVAL_W-1:0]   sums [TABLE_ENTRIES];
      bit                  live [TABLE_ENTRIES];
      reply_type           awaited_replies [$];
      int                  mismatches;

      function new();
         foreach (keys[i]) begin
            keys[i] = '0;
            counts[i] = '0;
            sums[i] = '0;
            live[i] = 1'b0;
         end
         mismatches = 0;
      endfunction

      static function int slot_of(logic [KEY_W-1:0] key);
         return key[31:0] % TABLE_ENTRIES;
      endfunction

      function void record_request(item_type req);
         int slot;
         reply_type r;
         slot = slot_of(req.key);
         r = '0;
         case (req.operation)
            OP_STORE: begin
               keys[slot] = req.key;
               counts[slot] = req.visits;
               sums[slot] = req.eval_sum;
               live[slot] = 1'b1;
            end
            OP_PROBE: begin
               // an invalid slot reads as key 0 and visits 0, which can never win
               if (live[slot] && keys[slot] == req.key && counts[slot] > req.visits) begin
                  r.take = 1'b1;
                  r.visits = counts[slot];
                  r.eval_sum = sums[slot];
               end
            end
            OP_CLEAR_ONE: live[slot] = 1'b0;
            OP_CLEAR_ALL: foreach (live[i]) live[i] = 1'b0;
         endcase
         awaited_replies.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: mismatch, %s", $time, what);
         mismatches++;
      endtask

      task check_reply(logic take, logic [VISITS_W-1:0] visits, logic [EVAL_W-1:0] eval_sum);
         reply_type want;
         if (awaited_replies.size() == 0) begin
            report_mismatch("reply with no transaction outstanding");
            return;
         end
         want = awaited_replies.pop_front();
         if (take !== want.take)
            report_mismatch($sformatf("take 0x%0h, expected 0x%0h", take, want.take));
         if (visits !== want.visits)
            report_mismatch($sformatf("visits_out 0x%0h, expected 0x%0h", visits, want.visits));
         if (eval_sum !== want.eval_sum)
            report_mismatch($sformatf("eval_out 0x%0h, expected 0x%0h", eval_sum, want.eval_sum));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   dmtt_req_if req_if ();
   dmtt_rsp_if rsp_if ();

   direct_mapped_transposition_table_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   transposition_scoreboard scoreboard;

   int                      hot_slot [HOT_SLOTS];
   logic [KEY_W-SLOT_W-1:0] upper_key [UPPER_KEYS];
   bit                      touched [TABLE_ENTRIES];
   int                      touched_list [$];
   int                      last_slot = 0;
   int                      clear_alls = 0;
   int                      burst_left = 0;
   int                      cycle_count;
   int                      stall_age = 0;
   logic [2:0]              stall_phase = '0;
   logic [7:0]              stall_mask = 8'hFF;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic item_type item_of(op_type op, logic [KEY_W-1:0] key,
                                        logic [VISITS_W-1:0] visits,
                                        logic [EVAL_W-1:0] eval_sum);
      item_type it;
      it.operation = op;
      it.key = key;
      it.visits = visits;
      it.eval_sum = eval_sum;
      return it;
   endfunction

   function automatic logic [KEY_W-1:0] key_for_slot(int slot);
      logic [KEY_W-1:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0)
         k[KEY_W-1:SLOT_W] = upper_key[$urandom_range(0, UPPER_KEYS-1)];
      k[SLOT_W-1:0] = slot[SLOT_W-1:0];
      return k;
   endfunction

   function automatic logic [VISITS_W-1:0] any_visits();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4, 5: return $urandom_range(0, 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [EVAL_W-1:0] any_eval();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return raw[EVAL_W-1:0];
      endcase
   endfunction

   function automatic item_type make_store();
      int slot;
      if ($urandom_range(0, 3) != 0)
         slot = hot_slot[$urandom_range(0, HOT_SLOTS-1)];
      else
         slot = $urandom_range(0, TABLE_ENTRIES-1);
      return item_of(OP_STORE, key_for_slot(slot), any_visits(), any_eval());
   endfunction

   // probes only go to slots written since reset
   function automatic item_type make_probe();
      int slot;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] flip;
      logic [VISITS_W-1:0] held;
      logic [VISITS_W-1:0] visits;
      if ($urandom_range(0, 2) == 0 && touched[last_slot])
         slot = last_slot;
      else
         slot = touched_list[$urandom_range(0, touched_list.size()-1)];
      key = scoreboard.keys[slot];
      case ($urandom_range(0, 9))
         0: begin
            flip = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0)
               flip = 64'd1 << $urandom_range(SLOT_W, KEY_W-1);
            flip[SLOT_W-1:0] = '0;
            if (flip == '0)
               flip[KEY_W-1] = 1'b1;
            key = key ^ flip;
         end
         1: key = key_for_slot(slot);
         default: ;
      endcase
      held = scoreboard.counts[slot];
      case ($urandom_range(0, 7))
         0, 1, 2: visits = held - 1;
         3: visits = held;
         4: visits = held + 1;
         5: visits = '0;
         6: visits = '1;
         default: visits = $urandom;
      endcase
      return item_of(OP_PROBE, key, visits, any_eval());
   endfunction

   function automatic item_type make_clear_one();
      logic [KEY_W-1:0] key;
      if ($urandom_range(0, 9) < 7 && touched_list.size() != 0)
         key = key_for_slot(touched_list[$urandom_range(0, touched_list.size()-1)]);
      else
         key = {$urandom, $urandom};
      return item_of(OP_CLEAR_ONE, key, any_visits(), any_eval());
   endfunction

   function automatic item_type make_clear_all();
      return item_of(OP_CLEAR_ALL, {$urandom, $urandom}, any_visits(), any_eval());
   endfunction

   function automatic item_type make_item(int clear_all_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < clear_all_pct)
         return make_clear_all();
      if (r < clear_all_pct + 10)
         return make_clear_one();
      if (r < clear_all_pct + 50 && touched_list.size() != 0)
         return make_probe();
      return make_store();
   endfunction

   task automatic send_request(item_type it);
      int slot;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 6)) begin
               @(negedge clock);
               req_if.valid = 1'b0;
            end
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.operation = it.operation;
      req_if.key = it.key;
      req_if.visits = it.visits;
      req_if.eval_sum = it.eval_sum;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      scoreboard.record_request(it);
      slot = transposition_scoreboard::slot_of(it.key);
      if (it.operation == OP_STORE) begin
         last_slot = slot;
         if (!touched[slot]) begin
            touched[slot] = 1'b1;
            touched_list.push_back(slot);
         end
      end
      if (it.operation == OP_CLEAR_ALL)
         clear_alls++;
   endtask

   task automatic run_directed();
      send_request(item_of(OP_STORE, 64'h0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      send_request(item_of(OP_PROBE, 64'h0, 32'hFFFF_FFFE, 48'h0));
      send_request(item_of(OP_PROBE, 64'h0, 32'hFFFF_FFFF, 48'h0));
      send_request(item_of(OP_STORE, '1, 32'd1, 48'h0));
      send_request(item_of(OP_PROBE, '1, 32'd0, '1));
      // key bits outside the slot select still take part in the compare
      send_request(item_of(OP_PROBE, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 48'h0));
      send_request(item_of(OP_PROBE, 64'hFFFF_FFFF_FFEF_FFFF, 32'd0, 48'h0));
      send_request(item_of(OP_STORE, 64'h1000, 32'd5, 48'h1234_5678_9ABC));
      send_request(item_of(OP_PROBE, 64'h0, 32'd0, 48'h0));
      send_request(item_of(OP_PROBE, 64'h1000, 32'd4, 48'h0));
      send_request(item_of(OP_CLEAR_ONE, 64'h0000_0000_7777_5000, 32'd0, 48'h0));
      send_request(item_of(OP_PROBE, 64'h1000, 32'd0, 48'h0));
      // cleared slot reads as key 0, visits 0
      send_request(item_of(OP_PROBE, 64'h0, 32'd0, 48'h0));
      send_request(item_of(OP_STORE, 64'hDEAD_BEEF_0000_0ABC, 32'd0, 48'd7));
      send_request(item_of(OP_PROBE, 64'hDEAD_BEEF_0000_0ABC, 32'd0, 48'h0));
      send_request(item_of(OP_STORE, 64'h5555_5555_AAAA_A123, 32'd100, 48'hAAAA_AAAA_AAAA));
      send_request(item_of(OP_PROBE, 64'h5555_5555_AAAA_A123, 32'd99, 48'h0));
      send_request(item_of(OP_CLEAR_ALL, 64'h0123_4567_89AB_CDEF, '1, '1));
      send_request(item_of(OP_PROBE, 64'h5555_5555_AAAA_A123, 32'd0, 48'h0));
      send_request(item_of(OP_PROBE, '1, 32'd0, 48'h0));
      send_request(item_of(OP_STORE, '1, 32'd2, 48'h5555_5555_5555));
      send_request(item_of(OP_PROBE, '1, 32'd1, 48'h0));
      send_request(item_of(OP_STORE, 64'hCAFE_0000_1234_5678, 32'd10, 48'd1));
      send_request(item_of(OP_STORE, 64'hCAFE_0000_1234_5678, 32'd20, 48'd2));
      send_request(item_of(OP_PROBE, 64'hCAFE_0000_1234_5678, 32'd15, 48'h0));
   endtask

   // receiver stalls on a repeating 8-bit mask that changes now and then
   always @(negedge clock) begin
      if (stall_age == 0) begin
         stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         stall_age = $urandom_range(16, 96);
      end
      stall_age--;
      stall_phase = stall_phase + 3'd1;
      rsp_if.ready = stall_mask[stall_phase];
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         scoreboard.check_reply(rsp_if.take, rsp_if.visits_out, rsp_if.eval_out);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [63:0] raw;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.operation = OP_STORE;
      req_if.key = '0;
      req_if.visits = '0;
      req_if.eval_sum = '0;
      rsp_if.ready = 1'b0;
      scoreboard = new();
      foreach (touched[i]) touched[i] = 1'b0;
      foreach (hot_slot[i]) hot_slot[i] = $urandom_range(0, TABLE_ENTRIES-1);
      hot_slot[0] = 0;
      hot_slot[1] = TABLE_ENTRIES - 1;
      foreach (upper_key[i]) begin
         raw = {$urandom, $urandom};
         upper_key[i] = raw[KEY_W-SLOT_W-1:0];
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      // enough clear-all transactions to wrap the epoch counter at least once
      while (clear_alls < CHURN_CLEARS) begin
         send_request(make_clear_all());
         repeat ($urandom_range(0, 3))
            send_request(make_item(0));
      end
      repeat (TAIL_ITEMS)
         send_request(make_item(3));
      @(negedge clock);
      req_if.valid = 1'b0;

      while (scoreboard.awaited_replies.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
